### src/rv_subset_instruction_executor_top_defines.svh
`ifndef RV_SUBSET_INSTRUCTION_EXECUTOR_TOP_DEFINES_SVH
`define RV_SUBSET_INSTRUCTION_EXECUTOR_TOP_DEFINES_SVH

// same-cycle implication
`define RVX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvx assertion failed");

// next-cycle implication
`define RVX_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvx assertion failed");

`endif

### src/rvx_pkg.sv
package rvx_pkg;

   localparam int DATA_WORDS_DEF = 65536;
   localparam int PC_BITS_DEF    = 16;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = 1;

   localparam logic [6:0] OPC_R      = 7'b0110011;
   localparam logic [6:0] OPC_I      = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] F7_BASE    = 7'b0000000;
   localparam logic [6:0] F7_ALT     = 7'b0100000;

   localparam logic [4:0]  SP_INDEX = 5'd2;
   localparam logic [31:0] SP_RESET = 32'd100;

   localparam logic [2:0] BR_EQ  = 3'd0;
   localparam logic [2:0] BR_NE  = 3'd1;
   localparam logic [2:0] BR_LT0 = 3'd2;
   localparam logic [2:0] BR_LT1 = 3'd3;
   localparam logic [2:0] BR_GE0 = 3'd4;
   localparam logic [2:0] BR_GE1 = 3'd5;

   typedef enum logic [3:0] {
      ALU_NONE, ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD, ALU_AND, ALU_OR,
      ALU_XOR, ALU_SLL, ALU_SRA, ALU_SLT
   } alu_op_type;

   typedef enum logic [2:0] {
      CLS_NONE, CLS_ALU_R, CLS_ALU_I, CLS_LOAD, CLS_STORE, CLS_BRANCH, CLS_JUMP
   } cls_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_DIV, ST_MEMRD, ST_DONE
   } state_type;

   typedef struct packed {
      cls_type     cls;
      alu_op_type  op;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
   } item_type;

   typedef struct packed {
      logic start;
      logic want_rem;
   } div_cmd_type;

   function automatic alu_op_type r_map0(input logic [2:0] f3);
      case (f3)
         3'd0:    return ALU_ADD;
         3'd1:    return ALU_SLL;
         3'd2:    return ALU_SLT;
         3'd3:    return ALU_SLT;
         3'd4:    return ALU_XOR;
         3'd5:    return ALU_SRA;
         3'd6:    return ALU_OR;
         default: return ALU_AND;
      endcase
   endfunction

   function automatic alu_op_type r_map1(input logic [2:0] f3);
      case (f3)
         3'd0:    return ALU_SUB;
         3'd1:    return ALU_MUL;
         3'd2:    return ALU_DIV;
         3'd3:    return ALU_MOD;
         3'd4:    return ALU_DIV;
         3'd5:    return ALU_SRA;
         default: return ALU_NONE;
      endcase
   endfunction

   function automatic alu_op_type i_map(input logic [2:0] f3);
      case (f3)
         3'd0:    return ALU_ADD;
         3'd1:    return ALU_SLT;
         3'd2:    return ALU_SLT;
         3'd3:    return ALU_AND;
         3'd4:    return ALU_OR;
         3'd5:    return ALU_XOR;
         3'd6:    return ALU_SLL;
         default: return ALU_SRA;
      endcase
   endfunction

endpackage

### src/rvx_front.sv
module rvx_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_instr_word,
   input  logic              init_done,
   input  logic              q_full,
   output logic              q_push,
   output rvx_pkg::item_type q_item
);
   import rvx_pkg::*;

   logic [31:0] w;
   logic [31:0] imm_i, imm_s, imm_j;
   alu_op_type  r_op;

   assign w     = req_instr_word;
   assign imm_i = {{20{w[31]}}, w[31:20]};
   assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
   assign imm_j = {{12{w[31]}}, w[31:12]};

   assign req_ready = init_done && !q_full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      if (w[31:25] == F7_BASE) begin
         r_op = r_map0(w[14:12]);
      end else if (w[31:25] == F7_ALT) begin
         r_op = r_map1(w[14:12]);
      end else begin
         r_op = ALU_NONE;
      end

      q_item.cls = CLS_NONE;
      q_item.op  = ALU_NONE;
      q_item.f3  = w[14:12];
      q_item.rd  = w[11:7];
      q_item.rs1 = w[19:15];
      q_item.rs2 = w[24:20];
      q_item.imm = imm_i;
      case (w[6:0])
         OPC_R: begin
            q_item.op  = r_op;
            q_item.cls = (r_op == ALU_NONE) ? CLS_NONE : CLS_ALU_R;
         end
         OPC_I: begin
            q_item.cls = CLS_ALU_I;
            q_item.op  = i_map(w[14:12]);
         end
         OPC_LOAD: begin
            q_item.cls = CLS_LOAD;
         end
         OPC_STORE: begin
            q_item.cls = CLS_STORE;
            q_item.imm = imm_s;
         end
         OPC_BRANCH: begin
            q_item.cls = CLS_BRANCH;
            q_item.imm = imm_s;
         end
         OPC_JALR: begin
            q_item.cls = CLS_JUMP;
         end
         OPC_JAL: begin
            q_item.cls = CLS_JUMP;
            q_item.imm = imm_j;
         end
         default: begin
            q_item.cls = CLS_NONE;
         end
      endcase
   end

endmodule

### src/rvx_queue.sv
module rvx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rvx_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output rvx_pkg::item_type head_item,
   output logic              empty
);
   import rvx_pkg::*;

   item_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/rvx_div.sv
module rvx_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rvx_pkg::div_cmd_type cmd,
   input  logic [31:0]          dividend,
   input  logic [31:0]          divisor,
   output logic                 done,
   output logic [31:0]          result
);
   import rvx_pkg::*;

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff, quo_ff, dvs_ff;
   logic        neg_q_ff, neg_r_ff, rem_sel_ff;
   logic [32:0] trial, diff;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign done  = done_ff;

   always_comb begin
      if (rem_sel_ff) begin
         result = neg_r_ff ? -rem_ff : rem_ff;
      end else begin
         result = neg_q_ff ? -quo_ff : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend[31] ? -dividend : dividend;
         dvs_ff     <= divisor[31] ? -divisor : divisor;
         neg_q_ff   <= dividend[31] ^ divisor[31];
         neg_r_ff   <= dividend[31];
         rem_sel_ff <= cmd.want_rem;
      end else if (busy_ff) begin
         rem_ff <= diff[32] ? trial[31:0] : diff[31:0];
         quo_ff <= {quo_ff[30:0], !diff[32]};
      end
   end

endmodule

### src/rvx_back.sv
`include "rv_subset_instruction_executor_top_defines.svh"

module rvx_back #(
   parameter int DATA_WORDS = rvx_pkg::DATA_WORDS_DEF,
   parameter int PC_BITS    = rvx_pkg::PC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  rvx_pkg::item_type q_head,
   output logic              q_pop,
   output logic              init_done,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_next_pc,
   output logic              rsp_branch_taken,
   output logic              rsp_reg_written,
   output logic [4:0]        rsp_dest_reg,
   output logic [31:0]       rsp_reg_value,
   output logic              rsp_mem_written,
   output logic [15:0]       rsp_mem_address,
   output logic [31:0]       rsp_mem_value
);
   import rvx_pkg::*;

   localparam int ADDR_BITS = $clog2(DATA_WORDS);

   state_type st_ff, st_in;
   item_type  item_ff;

   logic [31:0] rf_mem [32];
   logic [31:0] rf_vld_ff;
   logic [31:0] a_ff, b_ff;
   logic        avld_ff, bvld_ff;

   logic [31:0]          dmem [DATA_WORDS];
   logic [ADDR_BITS-1:0] clr_ff;
   logic                 clr_busy_ff;
   logic [31:0]          ld_ff;

   logic [PC_BITS-1:0]   pc_ff, nxt_ff;
   logic [31:0]          last_ff, res_ff, sum_ff, mv_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic                 taken_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_next_pc_ff, rsp_mem_address_ff;
   logic        rsp_branch_taken_ff, rsp_reg_written_ff, rsp_mem_written_ff;
   logic [4:0]  rsp_dest_reg_ff;
   logic [31:0] rsp_reg_value_ff, rsp_mem_value_ff;

   logic [31:0] opa, opb, rhs, alu_val, sum, pc32, next32, nxt32, addr32;
   logic        taken, wr, is_alu, is_mem;
   logic        ex_cap, ld_re, st_we, ld_cap, div_cap, commit;
   div_cmd_type div_cmd;
   logic        div_done;
   logic [31:0] div_res;

   function automatic logic [31:0] rf_init(input logic [4:0] idx);
      return (idx == SP_INDEX) ? SP_RESET : 32'd0;
   endfunction

   assign init_done = !clr_busy_ff;

   assign opa    = avld_ff ? a_ff : rf_init(item_ff.rs1);
   assign opb    = bvld_ff ? b_ff : rf_init(item_ff.rs2);
   assign rhs    = (item_ff.cls == CLS_ALU_R) ? opb : item_ff.imm;
   assign sum    = opa + item_ff.imm;
   assign pc32   = 32'(pc_ff);
   assign is_alu = (item_ff.cls == CLS_ALU_R) || (item_ff.cls == CLS_ALU_I);
   assign is_mem = (item_ff.cls == CLS_LOAD) || (item_ff.cls == CLS_STORE);
   assign wr     = (is_alu || item_ff.cls == CLS_LOAD || item_ff.cls == CLS_JUMP)
                   && (item_ff.rd != 5'd0);
   assign nxt32  = 32'(nxt_ff);
   assign addr32 = 32'(addr_ff);

   always_comb begin
      case (item_ff.op)
         ALU_ADD: alu_val = opa + rhs;
         ALU_SUB: alu_val = opa - rhs;
         ALU_MUL: alu_val = opa * rhs;
         ALU_AND: alu_val = opa & rhs;
         ALU_OR:  alu_val = opa | rhs;
         ALU_XOR: alu_val = opa ^ rhs;
         ALU_SLL: alu_val = opa << rhs[4:0];
         ALU_SRA: alu_val = 32'($signed(opa) >>> rhs[4:0]);
         ALU_SLT: alu_val = {31'd0, $signed(opa) < $signed(rhs)};
         default: alu_val = last_ff;
      endcase
   end

   always_comb begin
      case (item_ff.f3)
         BR_EQ:          taken = (opa == opb);
         BR_NE:          taken = (opa != opb);
         BR_LT0, BR_LT1: taken = $signed(opa) < $signed(opb);
         BR_GE0, BR_GE1: taken = !($signed(opa) < $signed(opb));
         default:        taken = 1'b0;
      endcase
      taken = taken && (item_ff.cls == CLS_BRANCH);
      if (taken || item_ff.cls == CLS_JUMP) begin
         next32 = pc32 + item_ff.imm;
      end else begin
         next32 = pc32 + 32'd1;
      end
   end

   always_comb begin
      st_in            = st_ff;
      q_pop            = 1'b0;
      ex_cap           = 1'b0;
      ld_re            = 1'b0;
      st_we            = 1'b0;
      ld_cap           = 1'b0;
      div_cap          = 1'b0;
      commit           = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.want_rem = (item_ff.op == ALU_MOD);
      case (st_ff)
         ST_IDLE: begin
            if (!q_empty && !clr_busy_ff) begin
               q_pop = 1'b1;
               st_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ex_cap = 1'b1;
            st_in  = ST_DONE;
            if (item_ff.cls == CLS_LOAD) begin
               ld_re = 1'b1;
               st_in = ST_MEMRD;
            end else if (item_ff.cls == CLS_STORE) begin
               st_we = 1'b1;
            end else if (is_alu && (item_ff.op == ALU_DIV || item_ff.op == ALU_MOD)
                         && rhs != 32'd0) begin
               div_cmd.start = 1'b1;
               st_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               div_cap = 1'b1;
               st_in   = ST_DONE;
            end
         end
         ST_MEMRD: begin
            ld_cap = 1'b1;
            st_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit = 1'b1;
               st_in  = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   rvx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (opa),
      .divisor  (rhs),
      .done     (div_done),
      .result   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rf_vld_ff    <= '0;
         clr_busy_ff  <= 1'b1;
         clr_ff       <= '0;
         pc_ff        <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(DATA_WORDS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= nxt_ff;
            if (wr) begin
               rf_vld_ff[item_ff.rd] <= 1'b1;
            end
            if (is_alu) begin
               last_ff <= res_ff;
            end else if (is_mem) begin
               last_ff <= sum_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_head;
         a_ff    <= rf_mem[q_head.rs1];
         b_ff    <= rf_mem[q_head.rs2];
         avld_ff <= rf_vld_ff[q_head.rs1];
         bvld_ff <= rf_vld_ff[q_head.rs2];
      end
      if (commit && wr) begin
         rf_mem[item_ff.rd] <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dmem[clr_ff] <= '0;
      end else if (st_we) begin
         dmem[sum[ADDR_BITS-1:0]] <= opb;
      end
      if (ld_re) begin
         ld_ff <= dmem[sum[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ex_cap) begin
         nxt_ff   <= next32[PC_BITS-1:0];
         taken_ff <= taken;
         sum_ff   <= sum;
         addr_ff  <= sum[ADDR_BITS-1:0];
         mv_ff    <= (item_ff.cls == CLS_STORE) ? opb : 32'd0;
         if (item_ff.cls == CLS_JUMP) begin
            res_ff <= pc32 + 32'd1;
         end else if (is_alu) begin
            res_ff <= alu_val;
         end else begin
            res_ff <= 32'd0;
         end
      end else if (ld_cap) begin
         res_ff <= ld_ff;
         mv_ff  <= ld_ff;
      end else if (div_cap) begin
         res_ff <= div_res;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_next_pc_ff      <= nxt32[15:0];
         rsp_branch_taken_ff <= taken_ff;
         rsp_reg_written_ff  <= wr;
         rsp_dest_reg_ff     <= item_ff.rd;
         rsp_reg_value_ff    <= wr ? res_ff : 32'd0;
         rsp_mem_written_ff  <= (item_ff.cls == CLS_STORE);
         rsp_mem_address_ff  <= is_mem ? addr32[15:0] : 16'd0;
         rsp_mem_value_ff    <= is_mem ? mv_ff : 32'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_next_pc_ff;
   assign rsp_branch_taken = rsp_branch_taken_ff;
   assign rsp_reg_written  = rsp_reg_written_ff;
   assign rsp_dest_reg     = rsp_dest_reg_ff;
   assign rsp_reg_value    = rsp_reg_value_ff;
   assign rsp_mem_written  = rsp_mem_written_ff;
   assign rsp_mem_address  = rsp_mem_address_ff;
   assign rsp_mem_value    = rsp_mem_value_ff;

   `RVX_ASSERT_IMP(a_clear_idle, clock, reset, clr_busy_ff, st_ff == ST_IDLE)
   `RVX_ASSERT_IMP(a_x0_never, clock, reset, 1'b1, !rf_vld_ff[0])
   `RVX_ASSERT_NXT(a_div_done, clock, reset, st_ff == ST_DIV && div_done, st_ff == ST_DONE)

endmodule

### src/rv_subset_instruction_executor_top.sv
// Word-addressed RV32I-subset executor: one instruction word in, one result word out.
// The front decodes each word into a two-entry queue; the back runs one instruction at
// a time from register read to commit: ALU, store, branch and jump words go from execute
// straight to commit, loads add a registered data memory read, and divide or modulo by
// a nonzero divisor adds the divider (one quotient bit per cycle in the shared divider).
// After reset the data memory is cleared one word per cycle, all DATA_WORDS words,
// during which req_ready stays low. DATA_WORDS must be a power of two.
module rv_subset_instruction_executor_top #(
   parameter int DATA_WORDS = rvx_pkg::DATA_WORDS_DEF,
   parameter int PC_BITS    = rvx_pkg::PC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_next_pc,
   output logic        rsp_branch_taken,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_reg,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_written,
   output logic [15:0] rsp_mem_address,
   output logic [31:0] rsp_mem_value
);
   import rvx_pkg::*;

   item_type push_item, head_item;
   logic     push, pop, full, empty, init_done;

   rvx_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_instr_word (req_instr_word),
      .init_done      (init_done),
      .q_full         (full),
      .q_push         (push),
      .q_item         (push_item)
   );

   rvx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .head_item (head_item),
      .empty     (empty)
   );

   rvx_back #(
      .DATA_WORDS (DATA_WORDS),
      .PC_BITS    (PC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (empty),
      .q_head           (head_item),
      .q_pop            (pop),
      .init_done        (init_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_mem_written  (rsp_mem_written),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_mem_value    (rsp_mem_value)
   );

endmodule

### test/tb_rv_subset_instruction_executor_top.sv
`timescale 1ns / 1ps

module tb_rv_subset_instruction_executor_top;
   import rvx_pkg::*;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        branch_taken;
      logic        reg_written;
      logic [4:0]  dest_reg;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [15:0] mem_address;
      logic [31:0] mem_value;
   } retire_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_instr_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_next_pc;
   logic        rsp_branch_taken;
   logic        rsp_reg_written;
   logic [4:0]  rsp_dest_reg;
   logic [31:0] rsp_reg_value;
   logic        rsp_mem_written;
   logic [15:0] rsp_mem_address;
   logic [31:0] rsp_mem_value;

   rv_subset_instruction_executor_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_instr_word(req_instr_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_next_pc(rsp_next_pc), .rsp_branch_taken(rsp_branch_taken),
      .rsp_reg_written(rsp_reg_written), .rsp_dest_reg(rsp_dest_reg),
      .rsp_reg_value(rsp_reg_value), .rsp_mem_written(rsp_mem_written),
      .rsp_mem_address(rsp_mem_address), .rsp_mem_value(rsp_mem_value)
   );

   always #6 clock = ~clock;

   logic [31:0] gpr [32];
   logic [31:0] dmem [int unsigned];
   logic [15:0] pc_q;
   logic [31:0] last_alu;
   retire_type  retire_q [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          errors = 0;
   int          words_sent = 0;
   int          words_checked = 0;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [31:0] alu_calc(alu_op_type op, logic [31:0] a, logic [31:0] b);
      longint q;
      case (op)
         ALU_ADD: return a + b;
         ALU_SUB: return a - b;
         ALU_MUL: return a * b;
         ALU_DIV, ALU_MOD: begin
            if (b == 0) return last_alu;
            if (op == ALU_DIV) q = longint'($signed(a)) / longint'($signed(b));
            else q = longint'($signed(a)) % longint'($signed(b));
            return q[31:0];
         end
         ALU_AND: return a & b;
         ALU_OR:  return a | b;
         ALU_XOR: return a ^ b;
         ALU_SLL: return a << b[4:0];
         ALU_SRA: return $signed(a) >>> b[4:0];
         ALU_SLT: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         default: return last_alu;
      endcase
   endfunction

   function automatic retire_type execute_word(logic [31:0] w);
      retire_type  r;
      alu_op_type  op;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a, b, imm_i, imm_s, imm_j, nx, val, sum;
      logic        wr;
      rd = w[11:7];
      f3 = w[14:12];
      f7 = w[31:25];
      a = gpr[w[19:15]];
      b = gpr[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_j = {{12{w[31]}}, w[31:12]};
      nx = {16'd0, pc_q} + 1;
      val = '0;
      wr = 1'b0;
      r = '0;
      case (w[6:0])
         OPC_R: begin
            op = ALU_NONE;
            if (f7 == F7_BASE) begin
               case (f3)
                  0: op = ALU_ADD;  1: op = ALU_SLL;  2, 3: op = ALU_SLT;
                  4: op = ALU_XOR;  5: op = ALU_SRA;  6: op = ALU_OR;
                  default: op = ALU_AND;
               endcase
            end else if (f7 == F7_ALT) begin
               case (f3)
                  0: op = ALU_SUB;  1: op = ALU_MUL;  2, 4: op = ALU_DIV;
                  3: op = ALU_MOD;  5: op = ALU_SRA;
                  default: op = ALU_NONE;
               endcase
            end
            if (op != ALU_NONE) begin
               val = alu_calc(op, a, b);
               last_alu = val;
               wr = 1'b1;
            end
         end
         OPC_I: begin
            case (f3)
               0: op = ALU_ADD;  1, 2: op = ALU_SLT;  3: op = ALU_AND;
               4: op = ALU_OR;   5: op = ALU_XOR;     6: op = ALU_SLL;
               default: op = ALU_SRA;
            endcase
            val = alu_calc(op, a, imm_i);
            last_alu = val;
            wr = 1'b1;
         end
         OPC_LOAD: begin
            sum = a + imm_i;
            last_alu = sum;
            r.mem_address = sum[15:0];
            r.mem_value = dmem.exists(sum[15:0]) ? dmem[sum[15:0]] : 32'd0;
            val = r.mem_value;
            wr = 1'b1;
         end
         OPC_STORE: begin
            sum = a + imm_s;
            last_alu = sum;
            r.mem_address = sum[15:0];
            dmem[sum[15:0]] = b;
            r.mem_value = b;
            r.mem_written = 1'b1;
         end
         OPC_BRANCH: begin
            case (f3)
               BR_EQ:          r.branch_taken = (a == b);
               BR_NE:          r.branch_taken = (a != b);
               BR_LT0, BR_LT1: r.branch_taken = ($signed(a) < $signed(b));
               BR_GE0, BR_GE1: r.branch_taken = ($signed(a) >= $signed(b));
               default:        r.branch_taken = 1'b0;
            endcase
            if (r.branch_taken) nx = {16'd0, pc_q} + imm_s;
         end
         OPC_JALR, OPC_JAL: begin
            val = {16'd0, pc_q} + 1;
            wr = 1'b1;
            nx = {16'd0, pc_q} + ((w[6:0] == OPC_JAL) ? imm_j : imm_i);
         end
         default: ;
      endcase
      if (wr && rd != 0) begin
         gpr[rd] = val;
         r.reg_written = 1'b1;
         r.reg_value = val;
      end
      pc_q = nx[15:0];
      r.next_pc = pc_q;
      r.dest_reg = rd;
      return r;
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OPC_R};
   endfunction

   function automatic logic [31:0] enc_i(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_s(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs2,
                                         logic [4:0] rs1, logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      retire_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (retire_q.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            e = retire_q.pop_front();
            words_checked++;
            if (rsp_next_pc !== e.next_pc) report_mismatch("next_pc", rsp_next_pc, e.next_pc);
            if (rsp_branch_taken !== e.branch_taken)
               report_mismatch("branch_taken", rsp_branch_taken, e.branch_taken);
            if (rsp_reg_written !== e.reg_written)
               report_mismatch("reg_written", rsp_reg_written, e.reg_written);
            if (rsp_dest_reg !== e.dest_reg) report_mismatch("dest_reg", rsp_dest_reg, e.dest_reg);
            if (rsp_reg_value !== e.reg_value)
               report_mismatch("reg_value", rsp_reg_value, e.reg_value);
            if (rsp_mem_written !== e.mem_written)
               report_mismatch("mem_written", rsp_mem_written, e.mem_written);
            if (rsp_mem_address !== e.mem_address)
               report_mismatch("mem_address", rsp_mem_address, e.mem_address);
            if (rsp_mem_value !== e.mem_value)
               report_mismatch("mem_value", rsp_mem_value, e.mem_value);
         end
      end
   end

   task automatic send_word(logic [31:0] w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instr_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      retire_q = {retire_q, execute_word(w)};
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (retire_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(enc_i(OPC_I, 12'hFFF, 0, 0, 1));             // x1 = -1
      send_word(enc_i(OPC_I, 12'h7FF, 0, 0, 3));             // x3 = 2047
      send_word(enc_i(OPC_I, 12'h001, 0, 0, 4));
      send_word(enc_i(OPC_I, 12'h01F, 4, 6, 4));             // x4 = min int
      send_word(enc_r(F7_ALT, 1, 4, 2, 5));                  // min / -1
      send_word(enc_r(F7_ALT, 1, 4, 3, 6));                  // min % -1
      send_word(enc_r(F7_ALT, 0, 3, 2, 7));                  // div by zero
      send_word(enc_r(F7_ALT, 0, 3, 3, 8));                  // mod by zero
      send_word(enc_r(F7_ALT, 3, 4, 1, 9));
      send_word(enc_r(F7_BASE, 3, 1, 1, 10));                // shift by 31
      send_word(enc_r(F7_ALT, 3, 4, 5, 11));
      send_word(enc_r(F7_BASE, 1, 4, 2, 12));
      send_word(enc_r(F7_ALT, 1, 3, 6, 13));                 // no entry
      send_word(enc_r(7'h7F, 1, 3, 0, 14));                  // bad f7
      send_word(enc_s(OPC_STORE, 12'h000, 4, 1, 2));         // address wraps to top
      send_word(enc_i(OPC_LOAD, 12'h000, 1, 2, 15));
      send_word(enc_i(OPC_I, 12'h005, 0, 0, 0));             // x0 stays zero
      for (int f = 0; f < 8; f++) send_word(enc_s(OPC_BRANCH, 12'hFFE, 1, 4, f[2:0]));
      send_word(enc_i(OPC_JALR, 12'h800, 5, 0, 16));
      send_word({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd17, OPC_JAL});
      send_word(32'hFFFF_FFFF);
   endtask

   task automatic test_random(int count);
      logic [31:0] w;
      logic [4:0]  r1, r2, rd;
      for (int n = 0; n < count; n++) begin
         w = $urandom;
         r1 = ($urandom_range(1)) ? w[19:15] : 5'($urandom_range(7));
         r2 = ($urandom_range(1)) ? w[24:20] : 5'($urandom_range(7));
         rd = ($urandom_range(1)) ? w[11:7] : 5'($urandom_range(7));
         case ($urandom_range(9))
            0, 1: w = enc_r(($urandom_range(5) == 0) ? w[31:25] :
                            ($urandom_range(1) ? F7_ALT : F7_BASE), r2, r1, w[14:12], rd);
            2, 3: w = enc_i(OPC_I, w[31:20], r1, w[14:12], rd);
            4: w = enc_i(OPC_LOAD, $urandom_range(1) ? 12'($urandom_range(15)) : w[31:20],
                         $urandom_range(1) ? 5'd0 : r1, w[14:12], rd);
            5: w = enc_s(OPC_STORE, $urandom_range(1) ? 12'($urandom_range(15)) : w[31:20],
                         r2, $urandom_range(1) ? 5'd0 : r1, w[14:12]);
            6: w = enc_s(OPC_BRANCH, w[31:20], r2, r1, w[14:12]);
            7: w = enc_i(OPC_JALR, w[31:20], r1, w[14:12], rd);
            8: w = {w[31:12], rd, OPC_JAL};
            default: ;
         endcase
         send_word(w);
      end
   endtask

   initial begin
      gpr = '{default: 32'd0};
      gpr[SP_INDEX] = SP_RESET;
      pc_q = '0;
      last_alu = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 7;
      recv_idle_pct = 83;
      test_random(175);
      drain_results();
      send_idle_pct = 83;
      recv_idle_pct = 7;
      test_random(175);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(175);
      drain_results();
      repeat (60) @(posedge clock);
      $display("covered all opcode classes, divide corner cases, wrapping addresses and jumps");
      $display("%0d words sent, %0d results checked, %0d mismatches",
               words_sent, words_checked, errors);
      if (errors == 0 && retire_q.size() == 0) begin
         $display("tb_rv_subset_instruction_executor_top: PASS");
      end else begin
         $display("tb_rv_subset_instruction_executor_top: FAIL");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("tb_rv_subset_instruction_executor_top: FAIL");
      $finish;
   end

endmodule
